### sv/tlpt_pkg.sv
// Shared types and constants for the two-level page table map/unmap block.
// Used by tlpt_store and two_level_page_table_map_unmap; no dependencies.
package tlpt_pkg;

    // Frame count of the word store (power of two)
    localparam int FRAME_COUNT = 1024;
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int IDX_W       = 10;
    localparam int WORDS_PER_FRAME = 1 << IDX_W;
    localparam int ADDR_W      = FRAME_W + IDX_W;
    localparam int DEPTH       = FRAME_COUNT * WORDS_PER_FRAME;
    localparam int WORD_W      = 32;
    localparam int NFF_W       = ((FRAME_W > 10) ? FRAME_W : 10) + 1;

    localparam int DIR_FRAME_W = 10;
    localparam int TAB_FRAME_W = 10;
    localparam int POOL_W      = 10;
    localparam logic [NFF_W-1:0] POOL_RESET = NFF_W'(48);
    localparam logic [WORD_W-1:0] ENTRY_FLAGS = 32'h0000_0007;
    localparam int PAGE_SHIFT  = 12;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_UNMAP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE        = 2'd0,
        STATUS_NEW_TABLE   = 2'd1,
        STATUS_NOT_PRESENT = 2'd2,
        STATUS_EXHAUSTED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ZERO,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

endpackage

### sv/tlpt_store.sv
// Single-port word store holding all page frames, with a registered read.
// Depends on tlpt_pkg for depth, widths and the request struct.
module tlpt_store (
    input  logic                         aclk,
    input  tlpt_pkg::mem_req_t           req,
    output logic [tlpt_pkg::WORD_W-1:0]  rdata
);

    logic [tlpt_pkg::WORD_W-1:0] mem [tlpt_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (req.en && req.we) begin
            mem[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.en && !req.we) begin
            rdata <= mem[req.addr];
        end
    end

endmodule

### sv/two_level_page_table_map_unmap.sv
// Item steps: accept with the directory read issued, directory entry check, table entry
// write, hand-off to the output register; this holds for a map of an existing table and
// for an unmap of a present page. A new table first has its frame cleared. An absent
// directory entry on unmap and an exhausted pool skip the entry write.
// One item at a time, bound by the single store port; the next item is taken
// while the result waits in the output register.
// Reset: synchronous, active low; afterwards the store is swept to zero, one word
// a cycle, before the first item is accepted.
module two_level_page_table_map_unmap (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,   // pool_start_frame
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,       // directory_frame, virtual_address, physical_address
    input  logic        s_tuser,       // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // table_frame
    output logic [1:0]  m_tuser        // status
);

    localparam int FW = tlpt_pkg::FRAME_W;
    localparam int IW = tlpt_pkg::IDX_W;
    localparam int AW = tlpt_pkg::ADDR_W;
    localparam int NW = tlpt_pkg::NFF_W;
    localparam int WW = tlpt_pkg::WORD_W;

    tlpt_pkg::state_t  state_reg, state_next;
    tlpt_pkg::op_t     op_reg, op_next;
    tlpt_pkg::status_t status_reg, status_next;
    tlpt_pkg::status_t m_status_reg, m_status_next;
    logic [FW-1:0] dir_reg, dir_next;
    logic [IW-1:0] dir_idx_reg, dir_idx_next;
    logic [IW-1:0] tab_idx_reg, tab_idx_next;
    logic [WW-1:0] pa_reg, pa_next;
    logic [FW-1:0] table_reg, table_next;
    logic [NW-1:0] nff_reg, nff_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0] m_frame_reg, m_frame_next;

    tlpt_pkg::mem_req_t mem_req;
    logic [WW-1:0]      mem_rdata;
    logic [FW-1:0]      pde_frame;
    logic [FW-1:0]      in_dir;
    logic               exhausted;

    tlpt_store u_store (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign in_dir    = FW'(s_tdata[9:0]);
    assign pde_frame = FW'(mem_rdata[WW-1:tlpt_pkg::PAGE_SHIFT]);
    assign exhausted = (nff_reg >= NW'(tlpt_pkg::FRAME_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tlpt_pkg::ST_CLEAR;
            cnt_reg      <= '0;
            nff_reg      <= tlpt_pkg::POOL_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            nff_reg      <= nff_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        dir_reg      <= dir_next;
        dir_idx_reg  <= dir_idx_next;
        tab_idx_reg  <= tab_idx_next;
        pa_reg       <= pa_next;
        table_reg    <= table_next;
        m_frame_reg  <= m_frame_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        m_status_next = m_status_reg;
        dir_next      = dir_reg;
        dir_idx_next  = dir_idx_reg;
        tab_idx_next  = tab_idx_reg;
        pa_next       = pa_reg;
        table_next    = table_reg;
        nff_next      = nff_reg;
        cnt_next      = cnt_reg;
        m_frame_next  = m_frame_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        mem_req       = '0;

        case (state_reg)
            tlpt_pkg::ST_CLEAR: begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = cnt_reg;
                cnt_next     = cnt_reg + AW'(1);
                if (cnt_reg == '1) begin
                    state_next = tlpt_pkg::ST_IDLE;
                end
            end
            tlpt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next      = tlpt_pkg::op_t'(s_tuser);
                    dir_next     = in_dir;
                    dir_idx_next = s_tdata[41:32];
                    tab_idx_next = s_tdata[31:22];
                    pa_next      = s_tdata[73:42];
                    mem_req.en   = 1'b1;
                    mem_req.addr = {in_dir, s_tdata[41:32]};
                    state_next   = tlpt_pkg::ST_READ;
                end
            end
            tlpt_pkg::ST_READ: begin
                if (mem_rdata[0]) begin
                    table_next  = pde_frame;
                    status_next = tlpt_pkg::STATUS_DONE;
                    state_next  = tlpt_pkg::ST_WRITE;
                end else if (op_reg == tlpt_pkg::OP_UNMAP) begin
                    table_next  = '0;
                    status_next = tlpt_pkg::STATUS_NOT_PRESENT;
                    state_next  = tlpt_pkg::ST_FINISH;
                end else if (exhausted) begin
                    table_next  = '0;
                    status_next = tlpt_pkg::STATUS_EXHAUSTED;
                    state_next  = tlpt_pkg::ST_FINISH;
                end else begin
                    table_next    = FW'(nff_reg);
                    nff_next      = nff_reg + NW'(1);
                    status_next   = tlpt_pkg::STATUS_NEW_TABLE;
                    mem_req.en    = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.addr  = {dir_reg, dir_idx_reg};
                    mem_req.wdata = (WW'(FW'(nff_reg)) << tlpt_pkg::PAGE_SHIFT)
                                    | tlpt_pkg::ENTRY_FLAGS;
                    cnt_next      = '0;
                    state_next    = tlpt_pkg::ST_ZERO;
                end
            end
            tlpt_pkg::ST_ZERO: begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = {table_reg, cnt_reg[IW-1:0]};
                cnt_next     = cnt_reg + AW'(1);
                if (cnt_reg[IW-1:0] == '1) begin
                    cnt_next   = '0;
                    state_next = tlpt_pkg::ST_WRITE;
                end
            end
            tlpt_pkg::ST_WRITE: begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = {table_reg, tab_idx_reg};
                if (op_reg == tlpt_pkg::OP_MAP) begin
                    mem_req.wdata = pa_reg | tlpt_pkg::ENTRY_FLAGS;
                end
                state_next = tlpt_pkg::ST_FINISH;
            end
            tlpt_pkg::ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_frame_next  = table_reg;
                    state_next    = tlpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlpt_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            nff_next = NW'(cfg_wr_data);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = 16'(m_frame_reg);

    a_zero_only_on_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlpt_pkg::ST_ZERO) |-> (op_reg == tlpt_pkg::OP_MAP))
        else $error("table clear entered for an unmap item");

    a_pool_moves_on_new_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (!cfg_wr_en && state_reg != tlpt_pkg::ST_READ) |=> (nff_reg == $past(nff_reg)))
        else $error("pool pointer moved outside a directory decision");

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlpt_pkg::ST_CLEAR || state_reg == tlpt_pkg::ST_ZERO) |-> !s_tready)
        else $error("item accepted during a clearing sweep");

    a_failed_has_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 16'd0))
        else $error("failed result carries a table frame");

endmodule
